FILE: rtl/lbt_pkg.sv
`default_nettype none
package lbt_pkg;

  localparam int CAPACITY = 16;
  localparam int FILE_W   = 8;
  localparam int BLOCK_W  = 24;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int RANK_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY) + 1;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_FILL     = 3'd1,
    ST_EVICT    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_FOUND    = 3'd4,
    ST_ABSENT   = 3'd5
  } status_t;

  // update applied by the cells in the update phase of an item
  typedef enum logic [2:0] {
    UPD_IDLE  = 3'd0,
    UPD_PIN   = 3'd1,
    UPD_UNPIN = 3'd2,
    UPD_TOUCH = 3'd3,
    UPD_LOAD  = 3'd4
  } upd_t;

  // broadcast to every cell
  typedef struct packed {
    upd_t               kind;
    logic [CNT_W-1:0]   limit;
    logic [FILE_W-1:0]  file_id;
    logic [BLOCK_W-1:0] block_number;
  } lbt_cmd_t;

  // handed from one cell to the next
  typedef struct packed {
    logic                free_seen;
    logic [CAPACITY-1:0] unpinned_ranks;
  } lbt_chain_t;

  // lookup result of one cell
  typedef struct packed {
    logic               hit;
    logic               first_free;
    logic               unpinned;
    logic [RANK_W-1:0]  rank;
    logic [FILE_W-1:0]  file_id;
    logic [BLOCK_W-1:0] block_number;
  } lbt_look_t;

endpackage
`default_nettype wire

FILE: rtl/lru_buffer_tags_with_pinning_unit.sv
`default_nettype none
// Tag and replacement unit of a fully associative buffer pool with pinning.
// Issue a command on in_operation / in_file_id / in_block_number with start;
// it is taken at a clock edge where start is high and busy is low.
// Access (0) looks the tag up: a hit makes the entry most recent, a miss
// fills the lowest free slot while fewer than active_capacity are held,
// otherwise evicts the least recent unpinned entry and returns its tag for
// write-back. Pin (1) and unpin (2) set or clear the mark of a present entry.
// Operation 3 is dropped without a result.
// A command passes capture, lookup across the cell row and update; operation 3 ends after the lookup.
// The result appears for one cycle with out_valid on the cycle after the
// update; busy drops at the same time, so a new command may follow at once.
// The lookup walks the chain of sixteen cells, which carries
// the free-slot search and the unpinned-rank mask from cell to cell.
// The receiver cannot stall: each transfer on the result side lasts exactly
// one cycle. cfg_wr_en writes active_capacity (0 acts as 1, above 16 acts
// as 16); write it only while idle. Reset empties every slot, clears pins
// and sets active_capacity to 16.
module lru_buffer_tags_with_pinning_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [lbt_pkg::OP_W-1:0]     in_operation,
  input  wire  [lbt_pkg::FILE_W-1:0]   in_file_id,
  input  wire  [lbt_pkg::BLOCK_W-1:0]  in_block_number,
  output logic                         out_valid,
  output logic [lbt_pkg::STATUS_W-1:0] out_status,
  output logic [lbt_pkg::SLOT_W-1:0]   out_slot,
  output logic [lbt_pkg::FILE_W-1:0]   out_evict_file_id,
  output logic [lbt_pkg::BLOCK_W-1:0]  out_evict_block_number,
  input  wire                          cfg_wr_en,
  input  wire  [lbt_pkg::CNT_W-1:0]    cfg_wr_data
);
  import lbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [FILE_W-1:0]   file_r;
  logic [BLOCK_W-1:0]  block_r;
  logic [CNT_W-1:0]    cap_r;
  logic [CNT_W-1:0]    held_r;

  // lookup results held for the update phase
  upd_t                upd_r;
  logic [CNT_W-1:0]    limit_r;
  logic [CAPACITY-1:0] sel_r;
  status_t             status_r;
  logic [SLOT_W-1:0]   slot_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [FILE_W-1:0]   out_file_r;
  logic [BLOCK_W-1:0]  out_block_r;

  lbt_cmd_t            cmd;
  lbt_chain_t          chain [CAPACITY+1];
  lbt_look_t           look  [CAPACITY];
  logic [CAPACITY-1:0] sel_vec;

  logic [CAPACITY-1:0] hit_vec, free_vec, victim_vec;
  logic [RANK_W-1:0]   hit_rank, victim_rank;
  logic [SLOT_W-1:0]   hit_slot, free_slot, victim_slot;
  logic [CNT_W-1:0]    cap_eff;
  logic [FILE_W-1:0]   sel_file;
  logic [BLOCK_W-1:0]  sel_block;

  assign busy = (state_r != S_IDLE);

  // row of cells; the chain carries the free search and the rank mask
  assign chain[0].free_seen      = 1'b0;
  assign chain[0].unpinned_ranks = '0;

  assign cmd.kind         = (state_r == S_APPLY) ? upd_r : UPD_IDLE;
  assign cmd.limit        = limit_r;
  assign cmd.file_id      = file_r;
  assign cmd.block_number = block_r;
  assign sel_vec          = sel_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lbt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel_vec[g]),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .look      (look[g])
    );
  end

  // reduce the cell lookups
  always_comb begin
    hit_rank    = '0;
    hit_slot    = '0;
    free_slot   = '0;
    victim_rank = '0;
    victim_slot = '0;
    sel_file    = '0;
    sel_block   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (chain[CAPACITY].unpinned_ranks[i]) victim_rank = RANK_W'(i);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]    = look[i].hit;
      free_vec[i]   = look[i].first_free;
      victim_vec[i] = look[i].unpinned && (look[i].rank == victim_rank);
      hit_rank      = hit_rank | (look[i].rank & {RANK_W{hit_vec[i]}});
      hit_slot      = hit_slot | (SLOT_W'(i) & {SLOT_W{hit_vec[i]}});
      free_slot     = free_slot | (SLOT_W'(i) & {SLOT_W{free_vec[i]}});
      victim_slot   = victim_slot | (SLOT_W'(i) & {SLOT_W{victim_vec[i]}});
      sel_file      = sel_file | (look[i].file_id & {FILE_W{sel_r[i]}});
      sel_block     = sel_block | (look[i].block_number & {BLOCK_W{sel_r[i]}});
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > CNT_W'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = cap_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = (op_r == OP_NONE) ? S_IDLE : S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CNT_W'(CAPACITY);
      held_r      <= '0;
      out_valid_r <= 1'b0;
      upd_r       <= UPD_IDLE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_APPLY);
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (state_r == S_APPLY && upd_r == UPD_LOAD && status_r == ST_FILL) begin
        held_r <= held_r + 1'b1;
      end
      // decide the update from the lookup
      if (state_r == S_LOOK) begin
        case (op_r)
          OP_PIN:   upd_r <= (|hit_vec) ? UPD_PIN : UPD_IDLE;
          OP_UNPIN: upd_r <= (|hit_vec) ? UPD_UNPIN : UPD_IDLE;
          OP_ACCESS: begin
            if (|hit_vec) begin
              upd_r <= UPD_TOUCH;
            end else if (held_r < cap_eff || (|chain[CAPACITY].unpinned_ranks)) begin
              upd_r <= UPD_LOAD;
            end else begin
              upd_r <= UPD_IDLE;
            end
          end
          default: upd_r <= UPD_IDLE;
        endcase
      end
    end
  end

  // capture the command, hold the lookup outcome, register the result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r    <= op_t'(in_operation);
      file_r  <= in_file_id;
      block_r <= in_block_number;
    end
    if (state_r == S_LOOK) begin
      sel_r    <= '0;
      limit_r  <= '0;
      slot_r   <= '0;
      if (op_r == OP_PIN || op_r == OP_UNPIN) begin
        if (|hit_vec) begin
          status_r <= ST_FOUND;
          sel_r    <= hit_vec;
          slot_r   <= hit_slot;
        end else begin
          status_r <= ST_ABSENT;
        end
      end else if (|hit_vec) begin
        status_r <= ST_HIT;
        sel_r    <= hit_vec;
        slot_r   <= hit_slot;
        limit_r  <= {1'b0, hit_rank};
      end else if (held_r < cap_eff) begin
        status_r <= ST_FILL;
        sel_r    <= free_vec;
        slot_r   <= free_slot;
        limit_r  <= CNT_W'(CAPACITY);
      end else if (|chain[CAPACITY].unpinned_ranks) begin
        status_r <= ST_EVICT;
        sel_r    <= victim_vec;
        slot_r   <= victim_slot;
        limit_r  <= {1'b0, victim_rank};
      end else begin
        status_r <= ST_OVERFLOW;
      end
    end
    if (state_r == S_APPLY) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_r;
      // cells still hold the old tag here: read it out for write-back
      out_file_r   <= (status_r == ST_EVICT) ? sel_file : '0;
      out_block_r  <= (status_r == ST_EVICT) ? sel_block : '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_slot               = out_slot_r;
  assign out_evict_file_id      = out_file_r;
  assign out_evict_block_number = out_block_r;

endmodule
`default_nettype wire

FILE: rtl/lbt_cell.sv
`default_nettype none
module lbt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lbt_pkg::lbt_cmd_t   cmd,
  input  wire                 sel,
  input  lbt_pkg::lbt_chain_t chain_in,
  output lbt_pkg::lbt_chain_t chain_out,
  output lbt_pkg::lbt_look_t  look
);
  import lbt_pkg::*;

  logic               valid_r;
  logic               pinned_r;
  logic [RANK_W-1:0]  rank_r;
  logic [FILE_W-1:0]  file_r;
  logic [BLOCK_W-1:0] block_r;
  logic [CAPACITY-1:0] rank_bit;

  always_comb begin
    rank_bit         = '0;
    rank_bit[rank_r] = valid_r & ~pinned_r;
  end

  assign chain_out.free_seen      = chain_in.free_seen | ~valid_r;
  assign chain_out.unpinned_ranks = chain_in.unpinned_ranks | rank_bit;

  assign look.hit          = valid_r && (file_r == cmd.file_id) && (block_r == cmd.block_number);
  assign look.first_free   = ~valid_r & ~chain_in.free_seen;
  assign look.unpinned     = valid_r & ~pinned_r;
  assign look.rank         = rank_r;
  assign look.file_id      = file_r;
  assign look.block_number = block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pinned_r <= 1'b0;
    end else begin
      case (cmd.kind)
        UPD_PIN:   if (sel) pinned_r <= 1'b1;
        UPD_UNPIN: if (sel) pinned_r <= 1'b0;
        UPD_LOAD: if (sel) begin
          valid_r  <= 1'b1;
          pinned_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // age the more recent entries, make the selected one most recent
  always_ff @(posedge clk) begin
    if (cmd.kind == UPD_TOUCH || cmd.kind == UPD_LOAD) begin
      if (sel) begin
        rank_r <= '0;
      end else if (valid_r && ({1'b0, rank_r} < cmd.limit)) begin
        rank_r <= rank_r + 1'b1;
      end
    end
    if (cmd.kind == UPD_LOAD && sel) begin
      file_r  <= cmd.file_id;
      block_r <= cmd.block_number;
    end
  end

endmodule
`default_nettype wire
